// ----- sv/sv39ptw_pkg.sv -----
package sv39ptw_pkg;

    localparam int ENTRIES_PER_PAGE = 512;
    localparam int VPN_W            = 9;
    localparam int PPN_W            = 44;
    localparam int FLAGS_W          = 10;
    localparam int WORD_W           = 64;
    localparam int INDEX_W          = 13;
    localparam int VA_BITS          = 39;

    localparam int BIT_V = 0;
    localparam int BIT_U = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_XLATE = 2'd2,
        OP_CLRU  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BIG     = 3'd1,
        ST_UPPER   = 3'd2,
        ST_LEAF    = 3'd3,
        ST_USER    = 3'd4,
        ST_OUTSIDE = 3'd5
    } status_t;

    typedef struct packed {
        op_t                op;
        status_t            pre;
        logic [VPN_W-1:0]   vpn2;
        logic [VPN_W-1:0]   vpn1;
        logic [VPN_W-1:0]   vpn0;
        logic [INDEX_W-1:0] word_index;
        logic [WORD_W-1:0]  word_data;
    } cmd_t;

    typedef struct packed {
        logic [3:0]       root_slot;
        logic [PPN_W-1:0] table_base_page;
    } cfg_t;

    typedef struct packed {
        status_t            status;
        logic [PPN_W-1:0]   phys_page;
        logic [FLAGS_W-1:0] leaf_flags;
        logic [WORD_W-1:0]  read_word;
    } res_t;

endpackage

// ----- sv/sv39_page_table_walker_top.sv -----
// Sv39 page-table walker with an internal table store.
// Input channel s_*: one request per item; s_tuser holds the opcode (write word,
// read word, translate, clear user bit), s_tdata the address, word index and data.
// Result channel m_*: exactly one result per request, in request order; m_tuser
// holds the status, m_tdata the page number, leaf flags and read word.
// APB port: root_slot at 0x0, table_base_page at 0x8; write only while idle.
// Path from accept to result: the front register and the command queue, then
// the back end, which answers a write or an early fault from idle, a read after
// a single store read, and a translate or clear after three dependent reads of
// the registered store, the last step also writing back the cleared entry.
// The walk sequencer finishes one command before it takes the next.
// After reset the store is cleared one word a cycle, all TABLE_PAGES * 512 words,
// with s_tready low; configuration writes are taken meanwhile.
// When m_tready is low the finished result is held in the output register and
// the front and the two-entry queue keep accepting requests until full.
module sv39_page_table_walker_top #(
    parameter int TABLE_PAGES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // vaddr[63:0], word_index[76:64], word_data[140:77]
    input  logic [1:0]   s_tuser,   // opcode[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // phys_page[43:0], leaf_flags[53:44], read_word[117:54]
    output logic [2:0]   m_tuser,   // status[2:0]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    localparam logic REG_ROOT_SLOT  = 1'b0;
    localparam logic REG_TABLE_BASE = 1'b1;

    logic [3:0]                    root_slot_reg;
    logic [sv39ptw_pkg::PPN_W-1:0] table_base_reg;
    sv39ptw_pkg::cfg_t             cfg;
    logic                          cfg_wr;

    logic                store_ready;
    logic                f_valid, f_ready;
    sv39ptw_pkg::cmd_t   f_cmd;
    logic                q_valid, q_pop;
    sv39ptw_pkg::cmd_t   q_cmd;
    sv39ptw_pkg::res_t   res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_slot_reg  <= '0;
            table_base_reg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3])
                REG_ROOT_SLOT:  root_slot_reg  <= pwdata[3:0];
                REG_TABLE_BASE: table_base_reg <= pwdata[sv39ptw_pkg::PPN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3])
            REG_ROOT_SLOT:  prdata = {60'b0, root_slot_reg};
            REG_TABLE_BASE: prdata = {20'b0, table_base_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.root_slot       = root_slot_reg;
    assign cfg.table_base_page = table_base_reg;

    sv39ptw_front #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .enable        (store_ready),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_op         (s_tuser),
        .in_vaddr      (s_tdata[63:0]),
        .in_word_index (s_tdata[76:64]),
        .in_word_data  (s_tdata[140:77]),
        .cmd_valid     (f_valid),
        .cmd_ready     (f_ready),
        .cmd           (f_cmd)
    );

    sv39ptw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_pop),
        .out_cmd   (q_cmd)
    );

    sv39ptw_back #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .store_ready (store_ready),
        .cmd_valid   (q_valid),
        .cmd_pop     (q_pop),
        .cmd         (q_cmd),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    assign m_tdata = {2'b0, res.read_word, res.leaf_flags, res.phys_page};
    assign m_tuser = res.status;

endmodule

// ----- sv/sv39ptw_front.sv -----
module sv39ptw_front #(
    parameter int TABLE_PAGES = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                enable,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          in_op,
    input  logic [63:0]                         in_vaddr,
    input  logic [sv39ptw_pkg::INDEX_W-1:0]     in_word_index,
    input  logic [sv39ptw_pkg::WORD_W-1:0]      in_word_data,
    output logic                                cmd_valid,
    input  logic                                cmd_ready,
    output sv39ptw_pkg::cmd_t                   cmd
);

    localparam int STORE_WORDS = TABLE_PAGES * sv39ptw_pkg::ENTRIES_PER_PAGE;

    logic               front_valid_reg;
    sv39ptw_pkg::cmd_t  front_cmd_reg;
    sv39ptw_pkg::cmd_t  cls_cmd;
    logic [31:0]        idx32;
    logic               idx_ok;
    logic               va_ok;

    assign idx32  = {{(32 - sv39ptw_pkg::INDEX_W){1'b0}}, in_word_index};
    assign idx_ok = idx32 < 32'(STORE_WORDS);
    assign va_ok  = (in_vaddr[63:sv39ptw_pkg::VA_BITS] == '0);

    always_comb begin
        cls_cmd.op         = sv39ptw_pkg::op_t'(in_op);
        cls_cmd.vpn2       = in_vaddr[38:30];
        cls_cmd.vpn1       = in_vaddr[29:21];
        cls_cmd.vpn0       = in_vaddr[20:12];
        cls_cmd.word_index = in_word_index;
        cls_cmd.word_data  = in_word_data;
        cls_cmd.pre        = sv39ptw_pkg::ST_OK;
        unique case (cls_cmd.op)
            sv39ptw_pkg::OP_WRITE, sv39ptw_pkg::OP_READ: begin
                if (!idx_ok) cls_cmd.pre = sv39ptw_pkg::ST_OUTSIDE;
            end
            default: begin
                if (!va_ok) cls_cmd.pre = sv39ptw_pkg::ST_BIG;
            end
        endcase
    end

    assign in_ready  = enable && (!front_valid_reg || cmd_ready);
    assign cmd_valid = front_valid_reg;
    assign cmd       = front_cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            front_valid_reg <= 1'b1;
        end else if (cmd_ready) begin
            front_valid_reg <= 1'b0;
        end
        if (in_valid && in_ready) begin
            front_cmd_reg <= cls_cmd;
        end
    end

endmodule

// ----- sv/sv39ptw_queue.sv -----
module sv39ptw_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  sv39ptw_pkg::cmd_t  in_cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output sv39ptw_pkg::cmd_t  out_cmd
);

    sv39ptw_pkg::cmd_t                  slots_reg [sv39ptw_pkg::QUEUE_DEPTH];
    logic [sv39ptw_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [sv39ptw_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [sv39ptw_pkg::QCNT_W-1:0]     count_reg;
    logic                               push;
    logic                               pop;

    assign in_ready  = count_reg < sv39ptw_pkg::QCNT_W'(sv39ptw_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = slots_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
        if (push) begin
            slots_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- sv/sv39ptw_back.sv -----
module sv39ptw_back #(
    parameter int TABLE_PAGES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  sv39ptw_pkg::cfg_t  cfg,
    output logic               store_ready,
    input  logic               cmd_valid,
    output logic               cmd_pop,
    input  sv39ptw_pkg::cmd_t  cmd,
    output logic               res_valid,
    input  logic               res_ready,
    output sv39ptw_pkg::res_t  res
);

    localparam int SLOT_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int AW     = SLOT_W + sv39ptw_pkg::VPN_W;
    localparam int DEPTH  = TABLE_PAGES * sv39ptw_pkg::ENTRIES_PER_PAGE;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RDWAIT,
        S_WALK,
        S_LEAF
    } state_t;

    logic [sv39ptw_pkg::WORD_W-1:0] store_mem [DEPTH];
    logic [sv39ptw_pkg::WORD_W-1:0] rdata_reg;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          clr_addr_reg, clr_addr_next;
    logic                   lvl_reg, lvl_next;
    sv39ptw_pkg::cmd_t      cmd_reg, cmd_next;
    logic [AW-1:0]          leaf_addr_reg, leaf_addr_next;
    logic                   res_valid_reg;
    sv39ptw_pkg::res_t      res_reg;

    logic                   rd_en, wr_en;
    logic [AW-1:0]          rd_addr, wr_addr;
    logic [sv39ptw_pkg::WORD_W-1:0] wr_data;
    logic                   produce;
    sv39ptw_pkg::res_t      res_next;
    logic                   out_free;

    logic [sv39ptw_pkg::PPN_W-1:0]  e_ppn;
    logic [sv39ptw_pkg::PPN_W:0]    diff;
    logic                   slot_bad;
    logic [SLOT_W-1:0]      next_slot;
    logic [31:0]            root32;
    logic                   root_bad;
    logic [31:0]            idx32;
    logic [sv39ptw_pkg::WORD_W-1:0] cleared;

    assign out_free  = !res_valid_reg || res_ready;
    assign e_ppn     = rdata_reg[53:10];
    assign diff      = {1'b0, e_ppn} - {1'b0, cfg.table_base_page};
    assign slot_bad  = diff[sv39ptw_pkg::PPN_W]
                    || (diff[sv39ptw_pkg::PPN_W-1:0] >= sv39ptw_pkg::PPN_W'(TABLE_PAGES));
    assign next_slot = diff[SLOT_W-1:0];
    assign root32    = {28'b0, cfg.root_slot};
    assign root_bad  = root32 >= 32'(TABLE_PAGES);
    assign idx32     = {{(32 - sv39ptw_pkg::INDEX_W){1'b0}}, cmd.word_index};
    assign cleared   = rdata_reg & ~(sv39ptw_pkg::WORD_W'(1) << sv39ptw_pkg::BIT_U);

    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        lvl_next       = lvl_reg;
        cmd_next       = cmd_reg;
        leaf_addr_next = leaf_addr_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        cmd_pop        = 1'b0;
        produce        = 1'b0;
        res_next       = '0;
        unique case (state_reg)
            S_CLEAR: begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_next = cmd;
                    unique case (cmd.op)
                        sv39ptw_pkg::OP_WRITE: begin
                            if (out_free) begin
                                cmd_pop         = 1'b1;
                                produce         = 1'b1;
                                res_next.status = cmd.pre;
                                if (cmd.pre == sv39ptw_pkg::ST_OK) begin
                                    wr_en   = 1'b1;
                                    wr_addr = idx32[AW-1:0];
                                    wr_data = cmd.word_data;
                                end
                            end
                        end
                        sv39ptw_pkg::OP_READ: begin
                            if (cmd.pre != sv39ptw_pkg::ST_OK) begin
                                if (out_free) begin
                                    cmd_pop         = 1'b1;
                                    produce         = 1'b1;
                                    res_next.status = cmd.pre;
                                end
                            end else begin
                                cmd_pop    = 1'b1;
                                rd_en      = 1'b1;
                                rd_addr    = idx32[AW-1:0];
                                state_next = S_RDWAIT;
                            end
                        end
                        default: begin
                            if (cmd.pre != sv39ptw_pkg::ST_OK || root_bad) begin
                                if (out_free) begin
                                    cmd_pop         = 1'b1;
                                    produce         = 1'b1;
                                    res_next.status = (cmd.pre != sv39ptw_pkg::ST_OK)
                                                    ? cmd.pre : sv39ptw_pkg::ST_OUTSIDE;
                                end
                            end else begin
                                cmd_pop    = 1'b1;
                                rd_en      = 1'b1;
                                rd_addr    = {root32[SLOT_W-1:0], cmd.vpn2};
                                lvl_next   = 1'b1;
                                state_next = S_WALK;
                            end
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                if (out_free) begin
                    produce            = 1'b1;
                    res_next.read_word = rdata_reg;
                    state_next         = S_IDLE;
                end
            end
            S_WALK: begin
                if (!rdata_reg[sv39ptw_pkg::BIT_V] || slot_bad) begin
                    if (out_free) begin
                        produce         = 1'b1;
                        res_next.status = !rdata_reg[sv39ptw_pkg::BIT_V]
                                        ? sv39ptw_pkg::ST_UPPER : sv39ptw_pkg::ST_OUTSIDE;
                        state_next      = S_IDLE;
                    end
                end else if (lvl_reg) begin
                    rd_en    = 1'b1;
                    rd_addr  = {next_slot, cmd_reg.vpn1};
                    lvl_next = 1'b0;
                end else begin
                    rd_en          = 1'b1;
                    rd_addr        = {next_slot, cmd_reg.vpn0};
                    leaf_addr_next = {next_slot, cmd_reg.vpn0};
                    state_next     = S_LEAF;
                end
            end
            S_LEAF: begin
                if (out_free) begin
                    produce    = 1'b1;
                    state_next = S_IDLE;
                    if (cmd_reg.op == sv39ptw_pkg::OP_CLRU) begin
                        wr_en               = 1'b1;
                        wr_addr             = leaf_addr_reg;
                        wr_data             = cleared;
                        res_next.phys_page  = cleared[53:10];
                        res_next.leaf_flags = cleared[9:0];
                    end else if (!rdata_reg[sv39ptw_pkg::BIT_V]) begin
                        res_next.status = sv39ptw_pkg::ST_LEAF;
                    end else if (!rdata_reg[sv39ptw_pkg::BIT_U]) begin
                        res_next.status = sv39ptw_pkg::ST_USER;
                    end else begin
                        res_next.phys_page  = rdata_reg[53:10];
                        res_next.leaf_flags = rdata_reg[9:0];
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // table store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) store_mem[wr_addr] <= wr_data;
        if (rd_en) rdata_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            lvl_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            lvl_reg      <= lvl_next;
            if (produce)        res_valid_reg <= 1'b1;
            else if (res_ready) res_valid_reg <= 1'b0;
        end
        cmd_reg       <= cmd_next;
        leaf_addr_reg <= leaf_addr_next;
        if (produce) res_reg <= res_next;
    end

    assign store_ready = state_reg != S_CLEAR;
    assign res_valid   = res_valid_reg;
    assign res         = res_reg;

`ifndef SYNTHESIS
    a_no_pop_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !cmd_pop)
        else $error("command taken during store clear");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        produce |-> out_free)
        else $error("result overwrites a waiting result");
    a_leaf_after_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_LEAF |-> $past(state_reg) == S_WALK || $past(state_reg) == S_LEAF)
        else $error("leaf state entered without a walk");
    a_walk_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK && state_next == S_LEAF |-> rd_en)
        else $error("walk step without a table read");
`endif

endmodule
